// ===== hw/rtl/lz4d_pkg.sv =====
// ----------------------------------------------------------------------------
// lz4d_pkg
// Types, status codes and header constants shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lz4d_pkg;

  localparam int LZ4D_QUEUE_DEPTH = 2;

  localparam int HDR_LEN     = 21;
  localparam int HDR_LAST    = HDR_LEN - 1;
  localparam int HDR_METHOD  = 8;
  localparam int HDR_CSIZE0  = 9;
  localparam int HDR_DSIZE0  = 13;
  localparam int HDR_POS_W   = 5;

  localparam logic [3:0] METHOD_RAW = 4'h1;
  localparam logic [3:0] METHOD_LZ4 = 4'h2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_BAD_METH  = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        data_valid;
    logic        payload_kind;
    logic [30:0] block_original_length;
    logic        block_end;
    logic        stream_end;
    logic [2:0]  status;
  } res_t;

  // "LZ4Block"
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h4C;
      3'd1: b = 8'h5A;
      3'd2: b = 8'h34;
      3'd3: b = 8'h42;
      3'd4: b = 8'h6C;
      3'd5: b = 8'h6F;
      3'd6: b = 8'h63;
      3'd7: b = 8'h6B;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lz4d_if.sv =====
// ----------------------------------------------------------------------------
// lz4d channel interfaces
// Valid/ready channels for the input byte stream and the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface lz4d_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface lz4d_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        data_valid;
  logic        payload_kind;
  logic [30:0] block_original_length;
  logic        block_end;
  logic        stream_end;
  logic [2:0]  status;
  modport source (output valid, out_byte, data_valid, payload_kind,
                  block_original_length, block_end, stream_end, status,
                  input ready);
  modport sink   (input valid, out_byte, data_valid, payload_kind,
                  block_original_length, block_end, stream_end, status,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lz4d_front.sv =====
// ----------------------------------------------------------------------------
// lz4d_front
// Header parser and payload tracker; classifies each byte, pushes results.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4d_front
  import lz4d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  lz4d_stream_if.sink stream,
  input  wire logic  space,
  output logic       push,
  output res_t       res
);

  logic [HDR_POS_W-1:0] header_position, header_position_next;
  logic                 magic_matched, magic_matched_next;
  logic [3:0]           block_method, block_method_next;
  logic [31:0]          compressed_size, compressed_size_next;
  logic [31:0]          decoded_size, decoded_size_next;
  logic [30:0]          payload_remaining, payload_remaining_next;
  logic                 in_payload, in_payload_next;
  logic                 error_latched, error_latched_next;

  logic        accept;
  logic [30:0] rem_dec;
  logic [2:0]  hdr_status;
  logic        kind;

  assign stream.ready = space;
  assign accept       = stream.valid && space;
  assign rem_dec      = payload_remaining - 31'd1;
  assign kind         = (block_method == METHOD_LZ4);

  // header check order: magic, lengths, method, raw length mismatch
  always_comb begin
    if (!magic_matched) begin
      hdr_status = ST_BAD_MAGIC;
    end else if (compressed_size[31] || decoded_size[31] ||
                 ((decoded_size == 32'd0) != (compressed_size == 32'd0))) begin
      hdr_status = ST_BAD_LEN;
    end else if (block_method != METHOD_RAW && block_method != METHOD_LZ4) begin
      hdr_status = ST_BAD_METH;
    end else if (block_method == METHOD_RAW && decoded_size != compressed_size) begin
      hdr_status = ST_BAD_LEN;
    end else begin
      hdr_status = ST_OK;
    end
  end

  always_comb begin
    logic clear;
    clear                  = 1'b0;
    push                   = 1'b0;
    res                    = '0;
    header_position_next   = header_position;
    magic_matched_next     = magic_matched;
    block_method_next      = block_method;
    compressed_size_next   = compressed_size;
    decoded_size_next      = decoded_size;
    payload_remaining_next = payload_remaining;
    in_payload_next        = in_payload;
    error_latched_next     = error_latched;

    if (accept) begin
      if (error_latched) begin
        clear = stream.in_last;
      end else if (in_payload) begin
        push                      = 1'b1;
        res.out_byte              = stream.in_byte;
        res.data_valid            = 1'b1;
        res.payload_kind          = kind;
        res.block_original_length = decoded_size[30:0];
        payload_remaining_next    = rem_dec;
        if (rem_dec == 31'd0) begin
          res.block_end        = 1'b1;
          in_payload_next      = 1'b0;
          header_position_next = '0;
        end
        if (stream.in_last) begin
          res.stream_end = 1'b1;
          if (rem_dec != 31'd0) res.status = ST_TRUNC;
          clear = 1'b1;
        end
      end else begin
        if (header_position == '0) begin
          magic_matched_next   = 1'b1;
          compressed_size_next = '0;
          decoded_size_next    = '0;
          block_method_next    = '0;
        end
        if (header_position < HDR_POS_W'(HDR_METHOD)) begin
          if (stream.in_byte != magic_byte(header_position[2:0])) magic_matched_next = 1'b0;
        end
        case (header_position)
          HDR_POS_W'(HDR_METHOD):     block_method_next          = stream.in_byte[7:4];
          HDR_POS_W'(HDR_CSIZE0):     compressed_size_next[7:0]   = stream.in_byte;
          HDR_POS_W'(HDR_CSIZE0 + 1): compressed_size_next[15:8]  = stream.in_byte;
          HDR_POS_W'(HDR_CSIZE0 + 2): compressed_size_next[23:16] = stream.in_byte;
          HDR_POS_W'(HDR_CSIZE0 + 3): compressed_size_next[31:24] = stream.in_byte;
          HDR_POS_W'(HDR_DSIZE0):     decoded_size_next[7:0]      = stream.in_byte;
          HDR_POS_W'(HDR_DSIZE0 + 1): decoded_size_next[15:8]     = stream.in_byte;
          HDR_POS_W'(HDR_DSIZE0 + 2): decoded_size_next[23:16]    = stream.in_byte;
          HDR_POS_W'(HDR_DSIZE0 + 3): decoded_size_next[31:24]    = stream.in_byte;
          default: ;
        endcase

        if (header_position < HDR_POS_W'(HDR_LAST)) begin
          header_position_next = header_position + HDR_POS_W'(1);
          if (stream.in_last) begin
            push           = 1'b1;
            res.stream_end = 1'b1;
            res.status     = ST_TRUNC;
            clear          = 1'b1;
          end
        end else begin
          header_position_next = '0;
          if (hdr_status != ST_OK) begin
            push       = 1'b1;
            res.status = hdr_status;
            if (stream.in_last) begin
              res.stream_end = 1'b1;
              clear          = 1'b1;
            end else begin
              error_latched_next = 1'b1;
            end
          end else begin
            res.payload_kind          = kind;
            res.block_original_length = decoded_size[30:0];
            if (compressed_size == 32'd0) begin
              push          = 1'b1;
              res.block_end = 1'b1;
              if (stream.in_last) begin
                res.stream_end = 1'b1;
                clear          = 1'b1;
              end
            end else begin
              in_payload_next        = 1'b1;
              payload_remaining_next = compressed_size[30:0];
              if (stream.in_last) begin
                push           = 1'b1;
                res.stream_end = 1'b1;
                res.status     = ST_TRUNC;
                clear          = 1'b1;
              end
            end
          end
        end
      end
    end

    if (clear) begin
      header_position_next   = '0;
      magic_matched_next     = 1'b1;
      block_method_next      = '0;
      compressed_size_next   = '0;
      decoded_size_next      = '0;
      payload_remaining_next = '0;
      in_payload_next        = 1'b0;
      error_latched_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position   <= '0;
      magic_matched     <= 1'b1;
      block_method      <= '0;
      compressed_size   <= '0;
      decoded_size      <= '0;
      payload_remaining <= '0;
      in_payload        <= 1'b0;
      error_latched     <= 1'b0;
    end else begin
      header_position   <= header_position_next;
      magic_matched     <= magic_matched_next;
      block_method      <= block_method_next;
      compressed_size   <= compressed_size_next;
      decoded_size      <= decoded_size_next;
      payload_remaining <= payload_remaining_next;
      in_payload        <= in_payload_next;
      error_latched     <= error_latched_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lz4d_queue.sv =====
// ----------------------------------------------------------------------------
// lz4d_queue
// Small result FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4d_queue
  import lz4d_pkg::*;
#(
  parameter int Depth = LZ4D_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  res_t      wr_data,
  output logic      space,
  input  wire logic pop,
  output logic      head_valid,
  output res_t      head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  res_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign space      = (count != CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && space;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lz4d_back.sv =====
// ----------------------------------------------------------------------------
// lz4d_back
// Output register stage driving the result channel from the queue head.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4d_back
  import lz4d_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     head_valid,
  input  res_t          head,
  output logic          pop,
  lz4d_result_if.source result
);

  logic out_valid;
  res_t out_data;

  assign pop = head_valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= head;
  end

  assign result.valid                 = out_valid;
  assign result.out_byte              = out_data.out_byte;
  assign result.data_valid            = out_data.data_valid;
  assign result.payload_kind          = out_data.payload_kind;
  assign result.block_original_length = out_data.block_original_length;
  assign result.block_end             = out_data.block_end;
  assign result.stream_end            = out_data.stream_end;
  assign result.status                = out_data.status;

endmodule

`default_nettype wire

// ===== hw/rtl/lz4_block_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// lz4_block_stream_deframer
// Splits a stream of framed LZ4 blocks into tagged payload bytes.
// ----------------------------------------------------------------------------
// Takes one byte per clock on the stream channel, sustained, as long as the
// result channel keeps up. Each block opens with a 21-byte header ("LZ4Block",
// method byte, LE compressed and original lengths, 4 checksum bytes that are
// skipped). Header bytes give no result, except the 21st (an error, an empty
// block, or a truncated stream) and any byte flagged in_last. Each payload
// byte comes out tagged raw/LZ4 with the block's original length; block_end
// marks the last one. A bad header is reported once and latched: later bytes
// are swallowed until the in_last byte, which restarts the parser. A stream
// ending mid-header or mid-payload reports truncated on its final result.
// Each result is registered in the queue and then in the output register
// before it is offered: the parser pushes into a two-entry queue when the
// byte is accepted, and the output stage pulls from it once its register is free.
// Ready on the stream side follows queue space only, so a stalled result
// port costs throughput only once the queue and the output register fill.
// Payload bytes are passed through; no LZ4 token decoding is done here.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4_block_stream_deframer
  import lz4d_pkg::*;
#(
  parameter int QueueDepth = LZ4D_QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  lz4d_stream_if.sink   stream,
  lz4d_result_if.source result
);

  // parser -> queue
  logic push;
  logic space;
  res_t res;

  // queue -> output stage
  logic head_valid;
  logic pop;
  res_t head;

  lz4d_front u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .space  (space),
    .push   (push),
    .res    (res)
  );

  lz4d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_data    (res),
    .space      (space),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lz4d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire

// ===== tb/lz4_deframe_checker.sv =====
// ----------------------------------------------------------------------------
// lz4_deframe_checker
// Watches both channels of the deframer, predicts each result from the
// accepted input bytes and compares the result stream field by field.
// ----------------------------------------------------------------------------
module lz4_deframe_checker
  import lz4d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  lz4d_stream_if  stream,
  lz4d_result_if  result,
  output int      fails,
  output int      pending,
  output int      n_results,
  output int      n_payload,
  output int      n_block_ends,
  output int      n_errors,
  output int      n_truncs
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] HDR_MAGIC = "LZ4Block";

  // parser state as seen by the predictor
  logic [4:0]  hdr_pos;
  logic        magic_ok;
  logic [3:0]  method;
  logic [31:0] csize;
  logic [31:0] dsize;
  logic [30:0] remaining;
  logic        in_data;
  logic        err_latched;

  res_t expected_q[$];

  function automatic void clear_state();
    hdr_pos     = '0;
    magic_ok    = 1'b1;
    method      = '0;
    csize       = '0;
    dsize       = '0;
    remaining   = '0;
    in_data     = 1'b0;
    err_latched = 1'b0;
  endfunction

  // priority: magic, sign/zero lengths, method, raw length mismatch
  function automatic logic [2:0] header_verdict();
    if (!magic_ok) return ST_BAD_MAGIC;
    if (csize[31] || dsize[31] || ((csize == 0) != (dsize == 0))) return ST_BAD_LEN;
    if (method != METHOD_RAW && method != METHOD_LZ4) return ST_BAD_METH;
    if (method == METHOD_RAW && csize != dsize) return ST_BAD_LEN;
    return ST_OK;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic last,
                              output bit produced, output res_t r);
    logic [4:0] pos;
    logic [2:0] st;
    r = '0;
    produced = 1'b0;
    if (err_latched) begin
      if (last) clear_state();
      return;
    end
    if (in_data) begin
      r.out_byte              = b;
      r.data_valid            = 1'b1;
      r.payload_kind          = (method == METHOD_LZ4);
      r.block_original_length = dsize[30:0];
      remaining = remaining - 1'b1;
      if (remaining == 0) begin
        r.block_end = 1'b1;
        in_data     = 1'b0;
        hdr_pos     = '0;
      end
      if (last) begin
        r.stream_end = 1'b1;
        if (in_data) r.status = ST_TRUNC;
        clear_state();
      end
      produced = 1'b1;
      return;
    end
    pos = hdr_pos;
    if (pos == 0) begin
      magic_ok = 1'b1;
      csize    = '0;
      dsize    = '0;
      method   = '0;
    end
    if (pos < HDR_METHOD) begin
      if (b != HDR_MAGIC[63 - 8*pos -: 8]) magic_ok = 1'b0;
    end else if (pos == HDR_METHOD) begin
      method = b[7:4];
    end else if (pos < HDR_DSIZE0) begin
      csize[8*(pos - HDR_CSIZE0) +: 8] = b;
    end else if (pos < HDR_DSIZE0 + 4) begin
      dsize[8*(pos - HDR_DSIZE0) +: 8] = b;
    end
    if (pos < HDR_LAST) begin
      hdr_pos = pos + 1'b1;
      if (last) begin
        r.stream_end = 1'b1;
        r.status     = ST_TRUNC;
        clear_state();
        produced = 1'b1;
      end
      return;
    end
    hdr_pos = '0;
    st = header_verdict();
    if (st != ST_OK) begin
      r.status = st;
      if (last) begin
        r.stream_end = 1'b1;
        clear_state();
      end else begin
        err_latched = 1'b1;
      end
      produced = 1'b1;
      return;
    end
    r.payload_kind          = (method == METHOD_LZ4);
    r.block_original_length = dsize[30:0];
    if (csize == 0) begin
      r.block_end = 1'b1;
      if (last) begin
        r.stream_end = 1'b1;
        clear_state();
      end
      produced = 1'b1;
      return;
    end
    in_data   = 1'b1;
    remaining = csize[30:0];
    if (last) begin
      r.stream_end = 1'b1;
      r.status     = ST_TRUNC;
      clear_state();
      produced = 1'b1;
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, seen);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    bit   made;
    res_t r;
    res_t want;
    if (rst) begin
      clear_state();
      expected_q.delete();
      fails        = 0;
      n_results    = 0;
      n_payload    = 0;
      n_block_ends = 0;
      n_errors     = 0;
      n_truncs     = 0;
    end else begin
      if (stream.valid && stream.ready) begin
        predict_byte(stream.in_byte, stream.in_last, made, r);
        if (made) expected_q.insert(expected_q.size(), r);
      end
      if (result.valid && result.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: byte 0x%0h dv %0b be %0b se %0b status %0d",
                   $time, result.out_byte, result.data_valid, result.block_end,
                   result.stream_end, result.status);
          fails++;
        end else begin
          want = expected_q.pop_front();
          compare_field("out_byte", 32'(want.out_byte), 32'(result.out_byte));
          compare_field("data_valid", 32'(want.data_valid), 32'(result.data_valid));
          compare_field("payload_kind", 32'(want.payload_kind), 32'(result.payload_kind));
          compare_field("block_original_length", 32'(want.block_original_length),
                        32'(result.block_original_length));
          compare_field("block_end", 32'(want.block_end), 32'(result.block_end));
          compare_field("stream_end", 32'(want.stream_end), 32'(result.stream_end));
          compare_field("status", 32'(want.status), 32'(result.status));
          if (want.data_valid) n_payload++;
          if (want.block_end) n_block_ends++;
          if (want.status == ST_TRUNC) n_truncs++;
          else if (want.status != ST_OK) n_errors++;
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives framed LZ4 block streams into the deframer: a directed set of
// header corner cases, then random streams of well-formed, broken, noisy and
// truncated blocks under four idling regimes. A checker instance predicts and
// compares every result; this module only makes stimulus and gives a verdict.
// ----------------------------------------------------------------------------
module testbench;
  import lz4d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Slowest plausible run is roughly 1000 bytes under heavy idling and
  // stalling; this limit leaves a wide margin over it.
  localparam int CYCLE_LIMIT = 400000;
  // Random bytes per idling phase; with the directed streams about 950 in all.
  localparam int PHASE_BYTES = 140;
  localparam int NO_MAGIC_FAULT = -1;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } stream_beat_t;

  logic clk;
  logic rst;

  lz4d_stream_if stream_ch ();
  lz4d_result_if result_ch ();

  int fails;
  int pending;
  int n_results;
  int n_payload;
  int n_block_ends;
  int n_errors;
  int n_truncs;

  int idle_pct;   // chance per cycle that the sender holds back
  int stall_pct;  // chance per cycle that the receiver drops ready
  int n_bytes;
  int n_streams;
  int cycles;

  stream_beat_t frame_q[$];

  lz4_block_stream_deframer uut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch)
  );

  lz4_deframe_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .stream       (stream_ch),
    .result       (result_ch),
    .fails        (fails),
    .pending      (pending),
    .n_results    (n_results),
    .n_payload    (n_payload),
    .n_block_ends (n_block_ends),
    .n_errors     (n_errors),
    .n_truncs     (n_truncs)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still expected", $time, pending);
      $display("[lz4_block_stream_deframer] ERROR");
      $finish;
    end
  end

  // Receiver side: ready redrawn every cycle against the current stall rate.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender: one transaction per call. Idle cycles are inserted up front so
  // that gaps land on every header position and payload byte alike.
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      stream_ch.valid <= 1'b0;
      @(posedge clk);
    end
    stream_ch.valid   <= 1'b1;
    stream_ch.in_byte <= b;
    stream_ch.in_last <= last;
    do @(posedge clk); while (!stream_ch.ready);
    n_bytes++;
  endtask

  // Hold the sender off until every predicted result has been taken.
  task automatic drain();
    stream_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // --------------------------------------------------------------------------
  // Stream assembly: bytes are collected in frame_q, the final one is marked
  // in_last and the lot is sent as one stream.
  // --------------------------------------------------------------------------
  task automatic put(input logic [7:0] v);
    frame_q.insert(frame_q.size(), stream_beat_t'{value: v, last: 1'b0});
  endtask

  task automatic put_payload(input int n);
    repeat (n) put(8'($urandom));
  endtask

  // Header with an optional corrupted magic byte; lengths go out little-endian,
  // checksum bytes are random as the block skips them.
  task automatic put_header(input logic [7:0] meth, input logic [31:0] csz,
                            input logic [31:0] dsz, input int bad_at);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) begin
      m = magic_byte(i[2:0]);
      if (i == bad_at) m = m ^ 8'($urandom_range(1, 255));
      put(m);
    end
    put(meth);
    for (int i = 0; i < 4; i++) put(csz[8*i +: 8]);
    for (int i = 0; i < 4; i++) put(dsz[8*i +: 8]);
    repeat (4) put(8'($urandom));
  endtask

  task automatic send_stream();
    if (frame_q.size() == 0) return;
    frame_q[frame_q.size() - 1].last = 1'b1;
    foreach (frame_q[i]) push_byte(frame_q[i].value, frame_q[i].last);
    frame_q.delete();
    n_streams++;
  endtask

  // Cut the stream short anywhere: mid-header, on the 21st byte or mid-payload.
  task automatic chop_stream();
    int cut;
    if (frame_q.size() < 2) return;
    cut = $urandom_range(1, frame_q.size() - 1);
    while (frame_q.size() > cut) void'(frame_q.pop_back());
  endtask

  // Valid method nibble; the low nibble is don't-care and randomised.
  function automatic logic [7:0] good_method();
    return {($urandom_range(1) ? METHOD_LZ4 : METHOD_RAW), 4'($urandom)};
  endfunction

  // Mostly short payloads, some empty blocks, a few longer ones.
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 90) return $urandom_range(1, 12);
    return $urandom_range(13, 64);
  endfunction

  // One header fault, of a sort chosen at random.
  task automatic put_bad_header();
    int n;
    int hi;
    logic [31:0] c;
    n = $urandom_range(1, 20);
    case ($urandom_range(5))
      0: put_header(good_method(), n, n, $urandom_range(7));
      1: begin
        // method nibble 0 or 3..15
        hi = $urandom_range(13);
        hi = (hi == 0) ? 0 : hi + 2;
        put_header({4'(hi), 4'($urandom)}, n, n, NO_MAGIC_FAULT);
      end
      2: begin
        c = $urandom_range(1, 40);
        put_header({METHOD_RAW, 4'($urandom)}, c, c + $urandom_range(1, 40), NO_MAGIC_FAULT);
      end
      3: put_header(good_method(), {1'b1, 31'($urandom)}, $urandom, NO_MAGIC_FAULT);
      4: put_header(good_method(), n, {1'b1, 31'($urandom)}, NO_MAGIC_FAULT);
      default: begin
        if ($urandom_range(1)) put_header(good_method(), 0, n, NO_MAGIC_FAULT);
        else put_header(good_method(), n, 0, NO_MAGIC_FAULT);
      end
    endcase
  endtask

  // A random stream of one to three blocks. Most are well formed; a header
  // fault or raw noise ends the block list, since later bytes are dropped.
  task automatic random_stream();
    int nblk;
    int roll;
    int n;
    logic [31:0] d;
    logic [7:0] meth;
    nblk = $urandom_range(1, 3);
    for (int k = 0; k < nblk; k++) begin
      roll = $urandom_range(99);
      if (roll < 76) begin
        n = pick_len();
        meth = good_method();
        d = n;
        if (meth[7:4] == METHOD_LZ4 && n != 0) begin
          case ($urandom_range(4))
            0, 1: d = n + $urandom_range(0, 200);
            2, 3: d = {1'b0, 31'($urandom)} | 32'd1;
            default: d = n;
          endcase
        end
        put_header(meth, n, d, NO_MAGIC_FAULT);
        put_payload(n);
      end else if (roll < 90) begin
        put_bad_header();
        put_payload($urandom_range(0, 6));
        break;
      end else begin
        put_payload($urandom_range(1, 24));
        break;
      end
    end
    if ($urandom_range(99) < 12) chop_stream();
    send_stream();
  endtask

  // --------------------------------------------------------------------------
  // Directed cases: one stream each.
  // --------------------------------------------------------------------------
  task automatic directed_streams();
    // empty block, in_last on the 21st byte
    put_header({METHOD_RAW, 4'h0}, 0, 0, NO_MAGIC_FAULT);
    send_stream();
    // raw with extreme payload bytes, LZ4 carrying the largest original
    // length, then an empty block closing the stream
    put_header({METHOD_RAW, 4'hF}, 2, 2, NO_MAGIC_FAULT);
    put(8'h00);
    put(8'hFF);
    put_header({METHOD_LZ4, 4'hA}, 3, 32'h7FFF_FFFF, NO_MAGIC_FAULT);
    put(8'hA5);
    put(8'h5A);
    put(8'hFF);
    put_header({METHOD_LZ4, 4'h0}, 0, 0, NO_MAGIC_FAULT);
    send_stream();
    // in_last on the byte that completes a block
    put_header({METHOD_LZ4, 4'h0}, 1, 5, NO_MAGIC_FAULT);
    put_payload(1);
    send_stream();
    // bad magic in the last and in the first position, junk swallowed
    put_header({METHOD_RAW, 4'h0}, 4, 4, 7);
    put_payload(4);
    send_stream();
    put_header({METHOD_LZ4, 4'h0}, 0, 0, 0);
    send_stream();
    // bad method
    put_header(8'h30, 4, 4, NO_MAGIC_FAULT);
    put_payload(3);
    send_stream();
    put_header(8'h00, 4, 4, NO_MAGIC_FAULT);
    put_payload(2);
    send_stream();
    // one length zero beats a bad method
    put_header(8'hF0, 5, 0, NO_MAGIC_FAULT);
    put_payload(2);
    send_stream();
    // raw lengths differ, error on the in_last byte itself
    put_header({METHOD_RAW, 4'h0}, 3, 4, NO_MAGIC_FAULT);
    send_stream();
    // negative compressed and original lengths
    put_header({METHOD_LZ4, 4'h0}, 32'h8000_0000, 5, NO_MAGIC_FAULT);
    put_payload(2);
    send_stream();
    put_header({METHOD_LZ4, 4'h0}, 2, 32'h8000_0001, NO_MAGIC_FAULT);
    send_stream();
    // truncated: on the first byte, mid-header, on the 21st byte, mid-payload
    put(8'h4C);
    send_stream();
    put_header({METHOD_RAW, 4'h0}, 6, 6, NO_MAGIC_FAULT);
    while (frame_q.size() > 5) void'(frame_q.pop_back());
    send_stream();
    put_header({METHOD_RAW, 4'h0}, 6, 6, NO_MAGIC_FAULT);
    send_stream();
    put_header({METHOD_LZ4, 4'h0}, 32'h7FFF_FFFF, 32'h7FFF_FFFF, NO_MAGIC_FAULT);
    put_payload(3);
    send_stream();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_start;
    rst               <= 1'b1;
    stream_ch.valid   <= 1'b0;
    stream_ch.in_byte <= '0;
    stream_ch.in_last <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    n_bytes   = 0;
    n_streams = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part with light idling on both sides
    idle_pct  = 20;
    stall_pct = 20;
    directed_streams();
    drain();

    // random part: no idling, sender idle, receiver stalling, both lightly;
    // each phase ends with the sender held until the result queue is empty
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      phase_start = n_bytes;
      while (n_bytes - phase_start < PHASE_BYTES) random_stream();
      drain();
    end

    // tail: let anything stray come out before the summary
    stall_pct = 0;
    repeat (10) @(posedge clk);

    $display("Covered %0d input bytes in %0d streams with %0d results checked:",
             n_bytes, n_streams, n_results);
    $display("  %0d payload bytes, %0d block ends, %0d header errors, %0d truncations",
             n_payload, n_block_ends, n_errors, n_truncs);
    if (fails == 0) begin
      $display("[lz4_block_stream_deframer] OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("[lz4_block_stream_deframer] ERROR");
    end
    $finish;
  end

endmodule

// ===== lz4_block_stream_deframer.f =====
hw/rtl/lz4d_pkg.sv
hw/rtl/lz4d_if.sv
hw/rtl/lz4d_front.sv
hw/rtl/lz4d_queue.sv
hw/rtl/lz4d_back.sv
hw/rtl/lz4_block_stream_deframer.sv
tb/lz4_deframe_checker.sv
tb/testbench.sv
